// ===== src/qfsa_pkg.sv =====
`timescale 1ns / 1ps
// qfsa_pkg: widths, reset values, register indexes and item types of the
// qrs fiducial slope alignment block; no dependencies
package qfsa_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int DIFF_W      = SAMPLE_W + 1;
   localparam int OFFSET_W    = 11;
   localparam int WINDOW_W    = 11;
   localparam int SPAN_CFG_W  = 7;
   localparam int COUNT_W     = 12;
   localparam int CORR_W      = 12;
   localparam int BASE_W      = 13;
   localparam int SUM_W       = 15;
   localparam int PEAK3_W     = SAMPLE_W + 2;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 11;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam int WINDOW_RESET = 200;
   localparam int SPAN_RESET   = 15;

   localparam logic signed [SUM_W-1:0] CORR_HIGH = SUM_W'(2047);
   localparam logic signed [SUM_W-1:0] CORR_LOW  = -SUM_W'(2048);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HALF_WINDOW = 4'd0,
      CSR_DIFF_SPAN   = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [OFFSET_W-1:0] cut_offset;
      logic                first_sample;
      logic                last_sample;
   } req_item_type;

   typedef struct packed {
      logic [CORR_W-1:0] correction;
      logic              positive;
   } rsp_item_type;

endpackage

// ===== src/qfsa_if.sv =====
`timescale 1ns / 1ps
// channel interfaces of the slope alignment block: sample input, result
// output and register write; depends on qfsa_pkg
interface qfsa_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [qfsa_pkg::SAMPLE_W-1:0] sample;
   logic [qfsa_pkg::OFFSET_W-1:0]        cut_offset;
   logic                                 first_sample;
   logic                                 last_sample;

   modport source (output valid, sample, cut_offset, first_sample, last_sample,
                   input ready);
   modport sink (input valid, sample, cut_offset, first_sample, last_sample,
                 output ready);
endinterface

interface qfsa_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [qfsa_pkg::CORR_W-1:0] correction;
   logic                               positive;

   modport source (output valid, correction, positive, input ready);
   modport sink (input valid, correction, positive, output ready);
endinterface

interface qfsa_csr_if;
   logic                               valid;
   logic                               ready;
   logic [qfsa_pkg::CSR_INDEX_W-1:0]   index;
   logic [qfsa_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/qfsa_track.sv =====
`timescale 1ns / 1ps
// qfsa_track: per-window peak and steepest-slope tracking and the result
// computed on the last sample; depends on qfsa_pkg
module qfsa_track #(
   parameter int MAX_SPAN = 64,
   parameter int SPAN_W   = $clog2(MAX_SPAN + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  fire,
   input  qfsa_pkg::req_item_type                item,
   input  logic [qfsa_pkg::SAMPLE_W-1:0]         old_sample,
   input  logic [SPAN_W-1:0]                     span,
   input  logic signed [qfsa_pkg::BASE_W-1:0]    base,
   output qfsa_pkg::rsp_item_type                result
);

   localparam int SW = qfsa_pkg::SAMPLE_W;
   localparam int DW = qfsa_pkg::DIFF_W;
   localparam int CW = qfsa_pkg::COUNT_W;
   localparam int OW = qfsa_pkg::OFFSET_W;
   localparam int UW = qfsa_pkg::SUM_W;
   localparam int PW = qfsa_pkg::PEAK3_W;

   logic [CW-1:0]        count_ff, count_in;
   logic signed [SW-1:0] high_ff, high_in, low_ff, low_in;
   logic signed [DW-1:0] rise_ff, rise_in, fall_ff, fall_in;
   logic [CW-1:0]        rise_idx_ff, rise_idx_in, fall_idx_ff, fall_idx_in;
   logic [OW-1:0]        offset_ff, offset_in;

   logic [CW-1:0]        count_cur, pos;
   logic signed [SW-1:0] high_cur, low_cur, s, high_new, low_new;
   logic signed [DW-1:0] rise_cur, fall_cur, rise_diff, fall_diff;
   logic signed [DW-1:0] rise_new, fall_new, best_sel;
   logic [CW-1:0]        rise_idx_cur, fall_idx_cur, rise_idx_new, fall_idx_new;
   logic [CW-1:0]        idx_sel;
   logic [OW-1:0]        offset_cur;
   logic                 diff_ok, positive;
   logic [PW-1:0]        high3, low2;
   logic [DW-1:0]        low_mag;
   logic signed [UW-1:0] sum;
   logic signed [UW-1:0] sat;

   always_comb begin
      // a first sample starts from a cleared window
      if (item.first_sample) begin
         count_cur    = '0;
         high_cur     = '0;
         low_cur      = '0;
         rise_cur     = '0;
         fall_cur     = '0;
         rise_idx_cur = '0;
         fall_idx_cur = '0;
         offset_cur   = item.cut_offset;
      end else begin
         count_cur    = count_ff;
         high_cur     = high_ff;
         low_cur      = low_ff;
         rise_cur     = rise_ff;
         fall_cur     = fall_ff;
         rise_idx_cur = rise_idx_ff;
         fall_idx_cur = fall_idx_ff;
         offset_cur   = offset_ff;
      end

      s        = $signed(item.sample);
      high_new = (s > high_cur) ? s : high_cur;
      low_new  = (s < low_cur) ? s : low_cur;

      diff_ok   = (span != '0) && (count_cur >= CW'(span));
      rise_diff = $signed({s[SW-1], s}) - $signed({old_sample[SW-1], old_sample});
      fall_diff = $signed({old_sample[SW-1], old_sample}) - $signed({s[SW-1], s});
      pos       = count_cur - CW'(span);

      rise_new     = rise_cur;
      rise_idx_new = rise_idx_cur;
      fall_new     = fall_cur;
      fall_idx_new = fall_idx_cur;
      if (diff_ok && (rise_diff > rise_cur)) begin
         rise_new     = rise_diff;
         rise_idx_new = pos;
      end
      if (diff_ok && (fall_diff > fall_cur)) begin
         fall_new     = fall_diff;
         fall_idx_new = pos;
      end

      // negative only when 3*high < 2*|low|; high is never negative, low never positive
      high3    = {1'b0, high_new[SW-1:0], 1'b0} + PW'(high_new[SW-1:0]);
      low_mag  = DW'(0) - {low_new[SW-1], low_new};
      low2     = {low_mag, 1'b0};
      positive = !(high3 < low2);

      best_sel = positive ? rise_new : fall_new;
      idx_sel  = positive ? rise_idx_new : fall_idx_new;

      sum = $signed({{(UW-CW){1'b0}}, idx_sel}) + $signed({{(UW-OW){1'b0}}, offset_cur})
          + $signed({{(UW-qfsa_pkg::BASE_W){base[qfsa_pkg::BASE_W-1]}}, base});
      if (sum > qfsa_pkg::CORR_HIGH) begin
         sat = qfsa_pkg::CORR_HIGH;
      end else if (sum < qfsa_pkg::CORR_LOW) begin
         sat = qfsa_pkg::CORR_LOW;
      end else begin
         sat = sum;
      end

      result.positive   = positive;
      result.correction = (best_sel > 0) ? sat[qfsa_pkg::CORR_W-1:0] : '0;

      count_in    = count_ff;
      high_in     = high_ff;
      low_in      = low_ff;
      rise_in     = rise_ff;
      fall_in     = fall_ff;
      rise_idx_in = rise_idx_ff;
      fall_idx_in = fall_idx_ff;
      offset_in   = offset_ff;
      if (fire) begin
         if (item.last_sample) begin
            count_in    = '0;
            high_in     = '0;
            low_in      = '0;
            rise_in     = '0;
            fall_in     = '0;
            rise_idx_in = '0;
            fall_idx_in = '0;
            offset_in   = '0;
         end else begin
            count_in    = (count_cur == qfsa_pkg::COUNT_MAX) ? count_cur : count_cur + 1'b1;
            high_in     = high_new;
            low_in      = low_new;
            rise_in     = rise_new;
            fall_in     = fall_new;
            rise_idx_in = rise_idx_new;
            fall_idx_in = fall_idx_new;
            offset_in   = offset_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         high_ff     <= '0;
         low_ff      <= '0;
         rise_ff     <= '0;
         fall_ff     <= '0;
         rise_idx_ff <= '0;
         fall_idx_ff <= '0;
         offset_ff   <= '0;
      end else begin
         count_ff    <= count_in;
         high_ff     <= high_in;
         low_ff      <= low_in;
         rise_ff     <= rise_in;
         fall_ff     <= fall_in;
         rise_idx_ff <= rise_idx_in;
         fall_idx_ff <= fall_idx_in;
         offset_ff   <= offset_in;
      end
   end

endmodule

// ===== src/qrs_fiducial_slope_align.sv =====
`timescale 1ns / 1ps
// qrs_fiducial_slope_align: top level with register file, sample delay memory,
// input and result registers; depends on qfsa_pkg, qfsa_if and qfsa_track
//
// Usage: samples of one beat window enter on req_ch, one per item, the first
// flagged by first_sample and carrying cut_offset, the last by last_sample.
// Each last sample gives one item on rsp_ch: the fiducial correction and the
// orientation flag; other samples give nothing.
// csr_ch writes the half search window (index 0) and diff_span (index 1); the
// user must write them only while idle, which the block does not enforce; other
// indexes are ignored. csr_ch.ready is always high.
// Throughput: one sample per cycle, but for a last sample held by a stalled
// rsp_ch, set by the update of the window state after the input register; the
// delay memory is read in the accept cycle, one write and one read port.
// A stalled rsp_ch holds its item; the input register keeps accepting plain
// samples and stops only when a last sample waits behind an untaken result.
// Reset (synchronous) restores the half window 200 and diff_span 15 and clears
// the window state; the delay memory needs no clearing.
module qrs_fiducial_slope_align #(
   parameter int MAX_SPAN = 64
) (
   input  logic        clock,
   input  logic        reset,
   qfsa_req_if.sink    req_ch,
   qfsa_rsp_if.source  rsp_ch,
   qfsa_csr_if.sink    csr_ch
);

   localparam int SPAN_W = $clog2(MAX_SPAN + 1);
   localparam int PTR_W  = $clog2(MAX_SPAN);
   localparam int SW     = qfsa_pkg::SAMPLE_W;
   localparam int BW     = qfsa_pkg::BASE_W;
   localparam int SPAN_RST = (qfsa_pkg::SPAN_RESET > MAX_SPAN) ? MAX_SPAN
                                                                : qfsa_pkg::SPAN_RESET;
   localparam int BASE_RST = SPAN_RST / 2 - qfsa_pkg::WINDOW_RESET;

   // configuration
   logic                             csr_fire;
   logic [qfsa_pkg::WINDOW_W-1:0]    window_ff, window_in;
   logic [SPAN_W-1:0]                span_ff, span_in;
   logic signed [BW-1:0]             base_ff, base_in;
   logic [qfsa_pkg::SPAN_CFG_W-1:0]  span_raw;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid & csr_ch.ready;
   assign span_raw     = csr_ch.data[qfsa_pkg::SPAN_CFG_W-1:0];

   always_comb begin
      window_in = window_ff;
      span_in   = span_ff;
      if (csr_fire) begin
         case (qfsa_pkg::csr_index_type'(csr_ch.index))
            qfsa_pkg::CSR_HALF_WINDOW: window_in = csr_ch.data[qfsa_pkg::WINDOW_W-1:0];
            qfsa_pkg::CSR_DIFF_SPAN: begin
               span_in = (32'(span_raw) > MAX_SPAN) ? SPAN_W'(MAX_SPAN) : SPAN_W'(span_raw);
            end
            default: ;
         endcase
      end
      // span/2 - half window, the constant part of the correction
      base_in = $signed(BW'(span_in >> 1)) - $signed(BW'(window_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= qfsa_pkg::WINDOW_W'(qfsa_pkg::WINDOW_RESET);
         span_ff   <= SPAN_W'(SPAN_RST);
         base_ff   <= BW'(BASE_RST);
      end else begin
         window_ff <= window_in;
         span_ff   <= span_in;
         base_ff   <= base_in;
      end
   end

   // input register and handshake
   logic                   req_fire, a_fire, out_free;
   logic                   a_valid_ff, a_valid_in;
   qfsa_pkg::req_item_type a_item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   qfsa_pkg::rsp_item_type rsp_item_ff, track_result;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign a_fire       = a_valid_ff && (!a_item_ff.last_sample || out_free);
   assign req_ch.ready = !a_valid_ff || a_fire;
   assign req_fire     = req_ch.valid & req_ch.ready;

   always_comb begin
      if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (a_fire) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
      if (a_fire && a_item_ff.last_sample) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // delay memory as a circular buffer; the read of span samples back is
   // registered alongside the item
   logic [SW-1:0]    line_mem [MAX_SPAN];
   logic [SW-1:0]    old_ff;
   logic [PTR_W-1:0] wp_ff, wp_in, rd_addr;
   logic [SPAN_W:0]  wp_x, rd_x;

   always_comb begin
      wp_x = (SPAN_W + 1)'(wp_ff);
      if (wp_x >= (SPAN_W + 1)'(span_ff)) begin
         rd_x = wp_x - (SPAN_W + 1)'(span_ff);
      end else begin
         rd_x = wp_x + (SPAN_W + 1)'(MAX_SPAN) - (SPAN_W + 1)'(span_ff);
      end
      rd_addr = rd_x[PTR_W-1:0];
      if (!req_fire) begin
         wp_in = wp_ff;
      end else if (wp_ff == PTR_W'(MAX_SPAN - 1)) begin
         wp_in = '0;
      end else begin
         wp_in = wp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         line_mem[wp_ff] <= req_ch.sample;
         old_ff          <= line_mem[rd_addr];
         a_item_ff       <= '{sample: req_ch.sample, cut_offset: req_ch.cut_offset,
                              first_sample: req_ch.first_sample,
                              last_sample: req_ch.last_sample};
      end
      if (a_fire && a_item_ff.last_sample) begin
         rsp_item_ff <= track_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         wp_ff        <= wp_in;
      end
   end

   qfsa_track #(
      .MAX_SPAN (MAX_SPAN),
      .SPAN_W   (SPAN_W)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .fire       (a_fire),
      .item       (a_item_ff),
      .old_sample (old_ff),
      .span       (span_ff),
      .base       (base_ff),
      .result     (track_result)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.correction = $signed(rsp_item_ff.correction);
   assign rsp_ch.positive   = rsp_item_ff.positive;

   // a last sample behind an untaken result stays in the input register
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready && a_valid_ff && a_item_ff.last_sample)
      |=> (a_valid_ff && a_item_ff.last_sample))
      else $error("last sample dropped while result stalled");

   // input is refused only while the input register holds an item
   ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> a_valid_ff)
      else $error("input refused with empty input register");

   // a new result appears only from a processed last sample
   result_from_last: assert property (@(posedge clock) disable iff (reset)
      (a_fire && !a_item_ff.last_sample && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result produced without a last sample");

   // write pointer stays inside the delay memory
   pointer_range: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (32'(wp_ff) < MAX_SPAN))
      else $error("delay memory pointer out of range");

   // correction base follows the configuration registers
   base_matches_cfg: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (base_ff == $signed(BW'(span_ff >> 1)) - $signed(BW'(window_ff))))
      else $error("correction base out of step with configuration");

endmodule

// ===== tb/qrs_fiducial_slope_align_tb.sv =====
`timescale 1ns / 1ps
// qrs_fiducial_slope_align_tb: self-checking bench for the slope alignment block, beat windows
// with random idling on both channels, results checked against a local predictor or directed values;
// depends on qfsa_pkg, qfsa_if and qrs_fiducial_slope_align
module qrs_fiducial_slope_align_tb;

   localparam int SPAN_LIMIT    = 64;
   localparam int OFFSET_TOP    = 1024;
   localparam int OFFSET_FULL   = 2047;
   localparam int WIDTH_TOP     = 1024;
   localparam int CORR_MAX      = 2047;
   localparam int CORR_MIN      = -2048;
   localparam int SETTLE_CYCLES = 6;
   localparam int GAP_MAX       = 12;
   localparam int PHASE_COUNT   = 11;
   localparam int PHASE_ITEMS   = 70;
   localparam int MAX_REPORTS   = 40;

   // register indexes the block does not decode
   localparam logic [qfsa_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LOW = 4'd2;
   localparam logic [qfsa_pkg::CSR_INDEX_W-1:0] CSR_SPARE_TOP = 4'd15;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;
   typedef enum {FLAW_NONE, FLAW_NO_START, FLAW_RESTART, FLAW_NO_END} flaw_type;
   typedef enum {SHAPE_NOISE, SHAPE_SPIKE, SHAPE_STEPS, SHAPE_EXTREMES} shape_type;

   typedef struct packed {
      row_kind_type                       kind;
      logic [qfsa_pkg::CSR_INDEX_W-1:0]   reg_index;
      int                                 value;
      int                                 offset;
      bit                                 first;
      bit                                 last;
      bit                                 typed;
      int                                 want_corr;
      bit                                 want_pos;
   } row_type;

   logic clock = 1'b0;
   logic reset;

   qfsa_req_if req_ch ();
   qfsa_rsp_if rsp_ch ();
   qfsa_csr_if csr_ch ();

   qrs_fiducial_slope_align DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // predictor state
   int unsigned                          width_cfg;
   int unsigned                          span_cfg;
   logic signed [qfsa_pkg::SAMPLE_W-1:0] history [SPAN_LIMIT];
   logic [qfsa_pkg::COUNT_W-1:0]         taken;
   logic signed [qfsa_pkg::SAMPLE_W-1:0] top_level;
   logic signed [qfsa_pkg::SAMPLE_W-1:0] bottom_level;
   logic signed [qfsa_pkg::DIFF_W-1:0]   rise_best;
   logic signed [qfsa_pkg::DIFF_W-1:0]   fall_best;
   logic [qfsa_pkg::COUNT_W-1:0]         rise_pos;
   logic [qfsa_pkg::COUNT_W-1:0]         fall_pos;
   logic [qfsa_pkg::OFFSET_W-1:0]        window_offset;

   qfsa_pkg::rsp_item_type due_results [$];
   row_type                directed_rows [$];
   int                     mismatch_count = 0;
   bit                     no_idle = 1'b0;

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   function automatic logic [qfsa_pkg::SAMPLE_W-1:0] to_sample(input int v);
      if (v > 32767) return qfsa_pkg::SAMPLE_W'(32767);
      if (v < -32768) return qfsa_pkg::SAMPLE_W'(-32768);
      return qfsa_pkg::SAMPLE_W'(v);
   endfunction

   function automatic void clear_beat();
      taken = '0;
      top_level = '0;
      bottom_level = '0;
      rise_best = '0;
      rise_pos = '0;
      fall_best = '0;
      fall_pos = '0;
      window_offset = '0;
   endfunction

   // one sample through the alignment; returns 1 with the correction on a last sample
   function automatic bit predict_alignment(input qfsa_pkg::req_item_type it,
                                            output qfsa_pkg::rsp_item_type res);
      int s;
      int older;
      int rise;
      int fall;
      int span;
      int corr;
      int k;
      bit upright;
      span = (span_cfg > SPAN_LIMIT) ? SPAN_LIMIT : int'(span_cfg);
      s = $signed(it.sample);
      res = '0;
      if (it.first_sample) begin
         clear_beat();
         window_offset = it.cut_offset;
      end
      if (s > top_level) top_level = qfsa_pkg::SAMPLE_W'(s);
      if (s < bottom_level) bottom_level = qfsa_pkg::SAMPLE_W'(s);
      if (span > 0 && int'(taken) >= span) begin
         older = history[span-1];
         rise = s - older;
         fall = older - s;
         // strict compare keeps the earliest position on ties
         if (rise > rise_best) begin
            rise_best = qfsa_pkg::DIFF_W'(rise);
            rise_pos = qfsa_pkg::COUNT_W'(int'(taken) - span);
         end
         if (fall > fall_best) begin
            fall_best = qfsa_pkg::DIFF_W'(fall);
            fall_pos = qfsa_pkg::COUNT_W'(int'(taken) - span);
         end
      end
      for (k = SPAN_LIMIT - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = it.sample;
      if (taken != qfsa_pkg::COUNT_MAX) taken = taken + 1'b1;
      if (it.last_sample) begin
         upright = !(3 * int'(top_level) < -2 * int'(bottom_level));
         corr = 0;
         if (upright && rise_best > 0)
            corr = int'(rise_pos) - int'(width_cfg) + int'(window_offset) + span / 2;
         else if (!upright && fall_best > 0)
            corr = int'(fall_pos) - int'(width_cfg) + int'(window_offset) + span / 2;
         if (corr > CORR_MAX) corr = CORR_MAX;
         if (corr < CORR_MIN) corr = CORR_MIN;
         res.correction = qfsa_pkg::CORR_W'(corr);
         res.positive = upright;
         clear_beat();
      end
      return it.last_sample;
   endfunction

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      // samples without a result may still sit in the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [qfsa_pkg::CSR_INDEX_W-1:0] index, input int data);
      logic [qfsa_pkg::CSR_DATA_W-1:0] bits;
      bits = qfsa_pkg::CSR_DATA_W'(data);
      wait_idle();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= bits;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      case (index)
         qfsa_pkg::CSR_HALF_WINDOW: width_cfg = bits;
         qfsa_pkg::CSR_DIFF_SPAN: span_cfg = bits[qfsa_pkg::SPAN_CFG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_item(input qfsa_pkg::req_item_type it, input bit typed,
                            input qfsa_pkg::rsp_item_type typed_res);
      int gap;
      qfsa_pkg::rsp_item_type predicted;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.sample <= it.sample;
      req_ch.cut_offset <= it.cut_offset;
      req_ch.first_sample <= it.first_sample;
      req_ch.last_sample <= it.last_sample;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (predict_alignment(it, predicted))
         due_results.push_back(typed ? typed_res : predicted);
   endtask

   function automatic void add_write(input logic [qfsa_pkg::CSR_INDEX_W-1:0] index,
                                     input int data);
      row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.reg_index = index;
      r.value = data;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_sample(input int value, input int offset, input bit first,
                                      input bit last, input bit typed, input int corr,
                                      input bit pos);
      row_type r;
      r = '0;
      r.kind = ROW_SAMPLE;
      r.value = value;
      r.offset = offset;
      r.first = first;
      r.last = last;
      r.typed = typed;
      r.want_corr = corr;
      r.want_pos = pos;
      directed_rows.push_back(r);
   endfunction

   // one beat window, mostly well formed; count tracks items sent in the phase
   task automatic random_window(inout int count);
      int span_eff;
      int len;
      int spike_at;
      int spread;
      int amp;
      int base;
      int d;
      int v;
      int k;
      int restart_at;
      int offset;
      shape_type shape;
      flaw_type flaw;
      qfsa_pkg::req_item_type it;
      span_eff = (span_cfg > SPAN_LIMIT) ? SPAN_LIMIT : int'(span_cfg);
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, span_eff + 1);
      else len = span_eff + $urandom_range(1, 16);
      shape = shape_type'($urandom_range(0, 3));
      flaw = ($urandom_range(0, 7) == 0) ? flaw_type'($urandom_range(1, 3)) : FLAW_NONE;
      // the window that ends the phase always closes
      if (flaw == FLAW_NO_END && count + len >= PHASE_ITEMS) flaw = FLAW_NONE;
      case ($urandom_range(0, 3))
         0: offset = 0;
         1: offset = OFFSET_TOP;
         default: offset = $urandom_range(0, OFFSET_TOP);
      endcase
      restart_at = (len > 1) ? $urandom_range(1, len - 1) : 0;
      spike_at = $urandom_range(0, len - 1);
      spread = $urandom_range(1, span_eff + 1);
      amp = int'($urandom_range(0, 64000)) - 32000;
      base = int'($urandom_range(0, 200)) - 100;
      for (k = 0; k < len; k++) begin
         case (shape)
            SHAPE_NOISE: v = int'($urandom_range(0, 65535)) - 32768;
            SHAPE_SPIKE: begin
               d = (k > spike_at) ? k - spike_at : spike_at - k;
               v = base + int'($urandom_range(0, 20)) - 10;
               if (d < spread) v = v + amp * (spread - d) / spread;
            end
            SHAPE_STEPS: v = (int'($urandom_range(0, 4)) - 2) * 1000;
            default: begin
               case ($urandom_range(0, 3))
                  0: v = -32768;
                  1: v = 32767;
                  2: v = 0;
                  default: v = -1;
               endcase
            end
         endcase
         it.sample = to_sample(v);
         it.cut_offset = (k == 0) ? qfsa_pkg::OFFSET_W'(offset)
                                  : qfsa_pkg::OFFSET_W'($urandom_range(0, OFFSET_TOP));
         it.first_sample = (k == 0 && flaw != FLAW_NO_START) ||
                           (flaw == FLAW_RESTART && k == restart_at);
         it.last_sample = (k == len - 1) && flaw != FLAW_NO_END;
         send_item(it, 1'b0, '0);
         count++;
      end
   endtask

   // flat noise with a step up at jump_at
   task automatic long_window(input int len, input int jump_at, input int offset);
      int k;
      int v;
      qfsa_pkg::req_item_type it;
      for (k = 0; k < len; k++) begin
         v = (k >= jump_at) ? 20000 : int'($urandom_range(0, 100)) - 50;
         it.sample = to_sample(v);
         it.cut_offset = (k == 0) ? qfsa_pkg::OFFSET_W'(offset)
                                  : qfsa_pkg::OFFSET_W'($urandom_range(0, OFFSET_TOP));
         it.first_sample = (k == 0);
         it.last_sample = (k == len - 1);
         send_item(it, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin : result_check
      qfsa_pkg::rsp_item_type want;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (due_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected item, expected none, got correction %0d positive %0b",
                        $time, rsp_ch.correction, rsp_ch.positive);
         end else begin
            want = due_results.pop_front();
            if (rsp_ch.correction !== want.correction) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: correction expected %0d, got %0d", $time,
                           $signed(want.correction), rsp_ch.correction);
            end
            if (rsp_ch.positive !== want.positive) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: positive expected %0b, got %0b", $time,
                           want.positive, rsp_ch.positive);
            end
         end
      end
   end

   // result side stalls
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
      end
   end

   initial begin
      #6ms;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      qfsa_pkg::req_item_type it;
      qfsa_pkg::rsp_item_type typed_res;
      row_type r;
      int phase;
      int phase_items;
      int ww;
      int sp;
      int k;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.sample <= '0;
      req_ch.cut_offset <= '0;
      req_ch.first_sample <= 1'b0;
      req_ch.last_sample <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data <= '0;
      width_cfg = qfsa_pkg::WINDOW_RESET;
      span_cfg = qfsa_pkg::SPAN_RESET;
      for (k = 0; k < SPAN_LIMIT; k++) history[k] = '0;
      clear_beat();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset values of the registers still in force
      add_sample(0, 0, 1'b0, 1'b1, 1'b1, 0, 1'b1);
      add_sample(-32768, 1024, 1'b1, 1'b1, 1'b1, 0, 1'b0);
      add_sample(32767, 0, 1'b1, 1'b1, 1'b1, 0, 1'b1);
      add_write(qfsa_pkg::CSR_HALF_WINDOW, 0);
      add_write(qfsa_pkg::CSR_DIFF_SPAN, 1);
      add_write(CSR_SPARE_LOW, 5);
      add_write(CSR_SPARE_TOP, 2047);
      // full-scale swings
      add_sample(-32768, 1024, 1'b1, 1'b0, 1'b0, 0, 1'b0);
      add_sample(32767, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
      add_sample(-32768, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
      add_sample(0, 0, 1'b0, 1'b1, 1'b1, 1024, 1'b1);
      // 3*max equals 2*|min|, stays positive
      add_sample(200, 3, 1'b1, 1'b0, 1'b0, 0, 1'b0);
      add_sample(-300, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
      add_sample(200, 0, 1'b0, 1'b1, 1'b0, 0, 1'b0);
      // equal rises, first position wins
      add_sample(0, 7, 1'b1, 1'b0, 1'b0, 0, 1'b0);
      add_sample(10, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
      add_sample(0, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
      add_sample(10, 0, 1'b0, 1'b1, 1'b0, 0, 1'b0);
      // negative orientation
      add_sample(100, 20, 1'b1, 1'b0, 1'b0, 0, 1'b0);
      add_sample(-300, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
      add_sample(0, 0, 1'b0, 1'b1, 1'b0, 0, 1'b0);
      // window opened without a start flag, its offset is ignored
      add_sample(5, 999, 1'b0, 1'b0, 1'b0, 0, 1'b0);
      add_sample(5, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
      add_sample(50, 0, 1'b0, 1'b1, 1'b0, 0, 1'b0);
      // second start flag restarts the window
      add_sample(1000, 0, 1'b1, 1'b0, 1'b0, 0, 1'b0);
      add_sample(-1000, 3, 1'b1, 1'b0, 1'b0, 0, 1'b0);
      add_sample(500, 0, 1'b0, 1'b1, 1'b0, 0, 1'b0);
      // zero span never forms a difference
      add_write(qfsa_pkg::CSR_DIFF_SPAN, 0);
      add_sample(-100, 50, 1'b1, 1'b0, 1'b0, 0, 1'b0);
      add_sample(30000, 0, 1'b0, 1'b1, 1'b1, 0, 1'b1);

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         if (r.kind == ROW_WRITE) begin
            write_reg(r.reg_index, r.value);
         end else begin
            it.sample = qfsa_pkg::SAMPLE_W'(r.value);
            it.cut_offset = qfsa_pkg::OFFSET_W'(r.offset);
            it.first_sample = r.first;
            it.last_sample = r.last;
            typed_res.correction = qfsa_pkg::CORR_W'(r.want_corr);
            typed_res.positive = r.want_pos;
            send_item(it, r.typed, typed_res);
         end
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin ww = 0; sp = 1; end
            1: begin ww = WIDTH_TOP; sp = SPAN_LIMIT; end
            2: begin ww = 37; sp = 0; end
            3: begin ww = $urandom_range(0, WIDTH_TOP); sp = 127; end
            // upper data bits dropped, raw span 65 clamped to 64
            4: begin ww = $urandom_range(0, WIDTH_TOP); sp = 1089; end
            5: begin ww = 512; sp = 2; end
            6: begin ww = WIDTH_TOP; sp = 3; end
            9: begin ww = qfsa_pkg::WINDOW_RESET; sp = qfsa_pkg::SPAN_RESET; end
            default: begin ww = $urandom_range(0, WIDTH_TOP); sp = $urandom_range(1, 16); end
         endcase
         write_reg(qfsa_pkg::CSR_HALF_WINDOW, ww);
         write_reg(qfsa_pkg::CSR_DIFF_SPAN, sp);
         no_idle = (phase == 6);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) random_window(phase_items);
      end

      // long window with an offset past its usual range: correction saturates high
      no_idle = 1'b1;
      write_reg(qfsa_pkg::CSR_HALF_WINDOW, 0);
      write_reg(qfsa_pkg::CSR_DIFF_SPAN, SPAN_LIMIT);
      long_window(300, 250, OFFSET_FULL);
      no_idle = 1'b0;

      wait_idle();
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
